>>> hw/rtl/bitmap_page_frame_allocator_macros.svh
// Assertion macros shared by the checker of the bitmap page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpfa check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpfa check failed");

`endif

>>> hw/rtl/bpfa_pkg.sv
// Package with constants, codes and types of the bitmap page frame allocator.
`timescale 1ns / 1ps

package bpfa_pkg;

	localparam int MAX_PAGES  = 4096;
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int CNT_W      = 13;
	localparam int ADDR_W     = 32;
	localparam int PAGE_SHIFT = 12;
	localparam int FPAGE_W    = ADDR_W - PAGE_SHIFT;
	localparam int SPAN_W     = FPAGE_W + 1;
	localparam int WORD_W     = 64;
	localparam int OFS_W      = $clog2(WORD_W);
	localparam int NUM_WORDS  = MAX_PAGES / WORD_W;
	localparam int WIDX_W     = $clog2(NUM_WORDS);
	localparam int RUN_W      = CNT_W + 1;
	localparam int POP_W      = OFS_W + 1;
	localparam int CMD_W      = 2;
	localparam int STS_W      = 3;

	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	localparam logic [STS_W-1:0] STS_OK    = 3'd0;
	localparam logic [STS_W-1:0] STS_ZERO  = 3'd1;
	localparam logic [STS_W-1:0] STS_FEW   = 3'd2;
	localparam logic [STS_W-1:0] STS_NORUN = 3'd3;
	localparam logic [STS_W-1:0] STS_NULL  = 3'd4;
	localparam logic [STS_W-1:0] STS_INV   = 3'd5;
	localparam logic [STS_W-1:0] STS_DBL   = 3'd6;

	typedef struct packed {
		logic              clear;
		logic              page0;
		logic              rd_en;
		logic [WIDX_W-1:0] rd_addr;
		logic              wr_en;
		logic [WIDX_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} map_req_t;

	typedef struct packed {
		logic [WIDX_W-1:0] word_idx;
		logic [OFS_W-1:0]  lo;
		logic [OFS_W-1:0]  hi;
		logic              set_op;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  run_in;
	} wu_ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] new_word;
		logic [POP_W-1:0]  pop;
		logic              any_free;
		logic              hit;
		logic [OFS_W-1:0]  hit_pos;
		logic [RUN_W-1:0]  run_out;
	} wu_res_t;

endpackage

>>> hw/rtl/bpfa_if.sv
// Channel interfaces of the bitmap page frame allocator: request, response and configuration.
`timescale 1ns / 1ps

interface bpfa_req_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::CMD_W-1:0]    cmd;
	logic [bpfa_pkg::CNT_W-1:0]    page_count;
	logic [bpfa_pkg::ADDR_W-1:0]   byte_addr;

	modport source (output valid, output cmd, output page_count, output byte_addr,
		input ready);
	modport sink (input valid, input cmd, input page_count, input byte_addr,
		output ready);
endinterface

interface bpfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::ADDR_W-1:0]   alloc_addr;
	logic [bpfa_pkg::STS_W-1:0]    status;
	logic [bpfa_pkg::CNT_W-1:0]    pages_done;
	logic [bpfa_pkg::CNT_W-1:0]    free_total;

	modport source (output valid, output alloc_addr, output status, output pages_done,
		output free_total, input ready);
	modport sink (input valid, input alloc_addr, input status, input pages_done,
		input free_total, output ready);
endinterface

interface bpfa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bpfa_pkg::CNT_W-1:0]    page_total;

	modport source (output valid, output page_total, input ready);
	modport sink (input valid, input page_total, output ready);
endinterface

>>> hw/rtl/bpfa_map.sv
// Used-page map storage: one word memory with per-row valid bits standing in for clearing.
`timescale 1ns / 1ps

module bpfa_map (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bpfa_pkg::map_req_t                     req,
	output logic [bpfa_pkg::WORD_W-1:0]            rd_data
);
	import bpfa_pkg::*;

	logic [WORD_W-1:0]    mem [0:NUM_WORDS-1];
	logic [NUM_WORDS-1:0] row_vld_q;
	logic                 page0_q;
	logic [WORD_W-1:0]    rd_raw_q;
	logic                 rd_vld_q;
	logic                 rd_row0_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem[req.rd_addr];
		end
	end

	// A row never written since the last init reads as the init image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			page0_q   <= 1'b1;
			rd_vld_q  <= 1'b0;
			rd_row0_q <= 1'b0;
		end else begin
			if (req.clear) begin
				row_vld_q <= '0;
				page0_q   <= req.page0;
			end else if (req.wr_en) begin
				row_vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q  <= row_vld_q[req.rd_addr];
				rd_row0_q <= (req.rd_addr == '0);
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : {{(WORD_W-1){1'b0}}, rd_row0_q & page0_q};

endmodule

>>> hw/rtl/bpfa_word_unit.sv
// Shared map word unit: first-fit run search, range masking, set or clear and popcount.
`timescale 1ns / 1ps

module bpfa_word_unit (
	input  logic [bpfa_pkg::WORD_W-1:0] word,
	input  bpfa_pkg::wu_ctl_t           ctl,
	output bpfa_pkg::wu_res_t           res
);
	import bpfa_pkg::*;

	localparam int CHUNKS = WORD_W / 8;

	logic [WORD_W-1:0] sel;
	logic [WORD_W-1:0] used;
	logic [WORD_W-1:0] hit_v;
	logic [POP_W-1:0]  pre [0:OFS_W][0:WORD_W-1];
	logic [RUN_W-1:0]  run_v [0:WORD_W-1];
	logic [3:0]        chunk_cnt [0:CHUNKS-1];
	logic [WORD_W-1:0] sel_used;

	always_comb begin
		for (int p = 0; p < WORD_W; p++) begin
			sel[p]    = (OFS_W'(p) >= ctl.lo) && (OFS_W'(p) <= ctl.hi);
			// Pages at or beyond the managed total behave as used for the search.
			used[p]   = word[p] | (CNT_W'({ctl.word_idx, OFS_W'(p)}) >= ctl.total);
			pre[0][p] = used[p] ? POP_W'(p + 1) : '0;
		end
		// Prefix scan: position of the highest used page at or below each bit, plus one.
		for (int l = 0; l < OFS_W; l++) begin
			for (int p = 0; p < WORD_W; p++) begin
				if ((p >= (1 << l)) && (pre[l][p] == '0)) begin
					pre[l+1][p] = pre[l][p - (1 << l)];
				end else begin
					pre[l+1][p] = pre[l][p];
				end
			end
		end
		for (int p = 0; p < WORD_W; p++) begin
			if (pre[OFS_W][p] == '0) begin
				run_v[p] = RUN_W'(ctl.run_in) + RUN_W'(p) + RUN_W'(1);
			end else begin
				run_v[p] = RUN_W'(p + 1) - RUN_W'(pre[OFS_W][p]);
			end
			hit_v[p] = !used[p] && (run_v[p] >= RUN_W'(ctl.count));
		end
	end

	assign sel_used = word & sel;

	always_comb begin
		res.hit_pos = '0;
		for (int p = WORD_W - 1; p >= 0; p--) begin
			if (hit_v[p]) begin
				res.hit_pos = OFS_W'(p);
			end
		end
		res.hit     = |hit_v;
		res.run_out = run_v[WORD_W-1];
		for (int c = 0; c < CHUNKS; c++) begin
			chunk_cnt[c] = '0;
			for (int b = 0; b < 8; b++) begin
				chunk_cnt[c] = chunk_cnt[c] + 4'(sel_used[c*8 + b]);
			end
		end
		res.pop = '0;
		for (int c = 0; c < CHUNKS; c++) begin
			res.pop = res.pop + POP_W'(chunk_cnt[c]);
		end
		res.new_word = ctl.set_op ? (word | sel) : (word & ~sel);
		res.any_free = |(sel & ~word);
	end

endmodule

>>> hw/rtl/bitmap_page_frame_allocator.sv
// Top level of the bitmap first-fit page frame allocator (one used bit per 4 KiB page).
// Init, no-op and rejected commands go from IDLE straight to DONE and load the output register.
// Alloc scans one 64-bit map word per cycle (at most all 64 words), then marks the run with a read
// and a write per touched word; free does so too, and skips a null page or out-of-range stretch.
// One item at a time, paced by the single map port and the shared word unit; ready in IDLE only.
// Reset: page total 4096, free count 4095, map reads clear except page 0; no clearing pass.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator (
	input  logic      clk,
	input  logic      arst_n,
	bpfa_cfg_if.sink  cfg,
	bpfa_req_if.sink  req,
	bpfa_rsp_if.source rsp
);
	import bpfa_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]         state_q, state_d;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
	logic               op_alloc_q, op_alloc_d;
	logic               set_op_q, set_op_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [PAGE_SHIFT-1:0] addr_lo_q, addr_lo_d;
	logic [FPAGE_W-1:0] cp_q, cp_d;
	logic [CNT_W-1:0]   rem_q, rem_d;
	logic [WIDX_W-1:0]  w_q, w_d;
	logic [CNT_W-1:0]   run_q, run_d;
	logic [PAGE_W-1:0]  start_q, start_d;
	logic [STS_W-1:0]   status_q, status_d;
	logic [CNT_W-1:0]   done_q, done_d;

	logic               rsp_valid_q;
	logic [ADDR_W-1:0]  rsp_addr_q;
	logic [STS_W-1:0]   rsp_status_q;
	logic [CNT_W-1:0]   rsp_done_q;
	logic [CNT_W-1:0]   rsp_free_q;
	logic               rsp_load;

	logic [CNT_W-1:0]   eff_total;
	logic               map_page0;
	logic [SPAN_W-1:0]  word_end;
	logic [SPAN_W-1:0]  rem_end;
	logic [SPAN_W-1:0]  tot_end;
	logic [SPAN_W-1:0]  hi_page;
	logic [POP_W-1:0]   seg_n;
	logic [SPAN_W-1:0]  oor_n;
	logic               cp_out;
	logic [CNT_W-1:0]   start_full;

	map_req_t           map_req;
	logic [WORD_W-1:0]  map_data;
	wu_ctl_t            wu_ctl;
	wu_res_t            wu_res;

	bpfa_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (map_req),
		.rd_data (map_data)
	);

	bpfa_word_unit u_word_unit (
		.word (map_data),
		.ctl  (wu_ctl),
		.res  (wu_res)
	);

	// Register values above the map size act as the map size.
	assign eff_total = (total_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_q;
	// The map itself fits in one page for any total up to the map size, so init reserves
	// page 0 unless the total is zero.
	assign map_page0 = (eff_total != '0);

	// Segment of the current word that the next read-modify-write covers: it ends at the
	// word boundary, at the last requested page or at the last managed page, whichever is first.
	assign word_end = {1'b0, cp_q[FPAGE_W-1:OFS_W], {OFS_W{1'b1}}};
	assign rem_end  = {1'b0, cp_q} + SPAN_W'(rem_q) - SPAN_W'(1);
	assign tot_end  = SPAN_W'(eff_total) - SPAN_W'(1);

	always_comb begin
		hi_page = word_end;
		if (rem_end < hi_page) begin
			hi_page = rem_end;
		end
		if (tot_end < hi_page) begin
			hi_page = tot_end;
		end
	end

	assign seg_n  = {1'b0, hi_page[OFS_W-1:0] - cp_q[OFS_W-1:0]} + POP_W'(1);
	// Pages from the current one up to the top of the 32-bit address space; they are all
	// out of range when the current page is.
	assign oor_n  = {1'b1, {FPAGE_W{1'b0}}} - {1'b0, cp_q};
	assign cp_out = (cp_q >= FPAGE_W'(eff_total));
	// Start of the run that ends at the hit in the word being searched; it may lie in an earlier word.
	assign start_full = CNT_W'({w_q, wu_res.hit_pos}) + CNT_W'(1) - count_q;

	always_comb begin
		wu_ctl.word_idx = w_q;
		wu_ctl.lo       = cp_q[OFS_W-1:0];
		wu_ctl.hi       = hi_page[OFS_W-1:0];
		wu_ctl.set_op   = set_op_q;
		wu_ctl.total    = eff_total;
		wu_ctl.count    = count_q;
		wu_ctl.run_in   = run_q;
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d    = state_q;
		free_cnt_d = free_cnt_q;
		op_alloc_d = op_alloc_q;
		set_op_d   = set_op_q;
		count_d    = count_q;
		addr_lo_d  = addr_lo_q;
		cp_d       = cp_q;
		rem_d      = rem_q;
		w_d        = w_q;
		run_d      = run_q;
		start_d    = start_q;
		status_d   = status_q;
		done_d     = done_q;
		map_req    = '0;
		map_req.page0   = map_page0;
		map_req.wr_addr = cp_q[PAGE_W-1:OFS_W];
		map_req.wr_data = wu_res.new_word;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					status_d   = STS_OK;
					done_d     = '0;
					op_alloc_d = 1'b0;
					count_d    = req.page_count;
					state_d    = S_DONE;
					case (req.cmd)
						CMD_INIT: begin
							// Clearing the row valid bits restores the init image without a clearing pass.
							map_req.clear = 1'b1;
							free_cnt_d    = eff_total - CNT_W'(map_page0);
						end
						CMD_ALLOC: begin
							op_alloc_d = 1'b1;
							if (req.page_count == '0) begin
								status_d = STS_ZERO;
							end else if (free_cnt_q < req.page_count) begin
								status_d = STS_FEW;
							end else begin
								// Fetch word 0 now so the search sees it next cycle.
								map_req.rd_en   = 1'b1;
								map_req.rd_addr = '0;
								w_d             = '0;
								run_d           = '0;
								state_d         = S_SRCH;
							end
						end
						CMD_FREE: begin
							if (req.page_count == '0) begin
								status_d = STS_ZERO;
							end else begin
								set_op_d  = 1'b0;
								cp_d      = req.byte_addr[ADDR_W-1:PAGE_SHIFT];
								addr_lo_d = req.byte_addr[PAGE_SHIFT-1:0];
								rem_d     = req.page_count;
								state_d   = S_RD;
							end
						end
						CMD_NOP: begin
							state_d = S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			S_SRCH: begin
				// One map word per cycle; the free run carries over word boundaries.
				if (wu_res.hit) begin
					start_d  = start_full[PAGE_W-1:0];
					cp_d     = FPAGE_W'(start_full);
					rem_d    = count_q;
					set_op_d = 1'b1;
					state_d  = S_RD;
				end else if (w_q == '1) begin
					status_d = STS_NORUN;
					state_d  = S_DONE;
				end else begin
					run_d           = wu_res.run_out[CNT_W-1:0];
					w_d             = w_q + WIDX_W'(1);
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = w_q + WIDX_W'(1);
				end
			end

			S_RD: begin
				if (!set_op_q && (cp_q == '0) && (addr_lo_q == '0)) begin
					// A byte address of zero is a null free: skip that single page.
					if (status_q == STS_OK) begin
						status_d = STS_NULL;
					end
					cp_d  = FPAGE_W'(1);
					rem_d = rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						state_d = S_DONE;
					end
				end else if (!set_op_q && cp_out) begin
					// Skip the whole out-of-range stretch up to the address wrap at once.
					if (status_q == STS_OK) begin
						status_d = STS_INV;
					end
					if (SPAN_W'(rem_q) <= oor_n) begin
						state_d = S_DONE;
					end else begin
						cp_d  = '0;
						rem_d = rem_q - oor_n[CNT_W-1:0];
					end
				end else begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = cp_q[PAGE_W-1:OFS_W];
					state_d         = S_WR;
				end
			end

			S_WR: begin
				// Read-modify-write of one word: set for alloc, clear for free.
				map_req.wr_en = 1'b1;
				if (set_op_q) begin
					free_cnt_d = free_cnt_q - CNT_W'(seg_n);
					done_d     = done_q + CNT_W'(seg_n);
				end else begin
					free_cnt_d = free_cnt_q + CNT_W'(wu_res.pop);
					done_d     = done_q + CNT_W'(wu_res.pop);
					if (wu_res.any_free && (status_q == STS_OK)) begin
						status_d = STS_DBL;
					end
				end
				cp_d  = cp_q + FPAGE_W'(seg_n);
				rem_d = rem_q - CNT_W'(seg_n);
				if (rem_q == CNT_W'(seg_n)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end

			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			total_q    <= CNT_W'(MAX_PAGES);
			free_cnt_q <= CNT_W'(MAX_PAGES - 1);
			status_q   <= STS_OK;
			done_q     <= '0;
			op_alloc_q <= 1'b0;
			set_op_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_cnt_q <= free_cnt_d;
			status_q   <= status_d;
			done_q     <= done_d;
			op_alloc_q <= op_alloc_d;
			set_op_q   <= set_op_d;
			if (cfg.valid) begin
				total_q <= cfg.page_total;
			end
		end
	end

	// Work registers of the current item; the sequencer always loads them before use.
	always_ff @(posedge clk) begin
		count_q   <= count_d;
		addr_lo_q <= addr_lo_d;
		cp_q      <= cp_d;
		rem_q     <= rem_d;
		w_q       <= w_d;
		run_q     <= run_d;
		start_q   <= start_d;
	end

	// Output register: a finished result waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			if (op_alloc_q && (status_q == STS_OK)) begin
				rsp_addr_q <= {{(ADDR_W-PAGE_W-PAGE_SHIFT){1'b0}}, start_q,
					{PAGE_SHIFT{1'b0}}};
			end else begin
				rsp_addr_q <= '0;
			end
			rsp_status_q <= status_q;
			rsp_done_q   <= done_q;
			rsp_free_q   <= free_cnt_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.alloc_addr = rsp_addr_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.pages_done = rsp_done_q;
	assign rsp.free_total = rsp_free_q;

endmodule

>>> hw/rtl/bpfa_checker.sv
// Port-level checker of the bitmap page frame allocator and its bind to the top level.
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_macros.svh"

module bpfa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bpfa_pkg::ADDR_W-1:0]   alloc_addr,
	input logic [bpfa_pkg::STS_W-1:0]    status,
	input logic [bpfa_pkg::CNT_W-1:0]    pages_done,
	input logic [bpfa_pkg::CNT_W-1:0]    free_total
);
	import bpfa_pkg::*;

	// A stalled response holds its payload.
	`BPFA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(alloc_addr) && $stable(status) && $stable(pages_done) && $stable(free_total))

	// The block works on one transaction at a time.
	`BPFA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)

	// A rejected allocation touches no page and returns no address.
	`BPFA_ASSERT_IMP(a_reject_empty, clk, arst_n, rsp_valid && (status == STS_ZERO || status == STS_FEW || status == STS_NORUN), pages_done == '0 && alloc_addr == '0)

	// Returned addresses are page aligned and appear only on success.
	`BPFA_ASSERT_IMP(a_addr_ok, clk, arst_n, rsp_valid, alloc_addr[PAGE_SHIFT-1:0] == '0 && (alloc_addr == '0 || status == STS_OK))

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.alloc_addr (rsp.alloc_addr),
	.status     (rsp.status),
	.pages_done (rsp.pages_done),
	.free_total (rsp.free_total)
);
